// File: rtl/pop_pkg.sv
package pop_pkg;

  localparam int BASIS_FRAC_BITS_DEF = 15;
  localparam int NORMAL_FRAC_BITS    = 8;

  localparam int NORMAL_W  = 16;
  localparam int OFFSET_W  = 4;
  localparam int COORD_W   = 24;
  localparam int OUT_W     = 26;
  localparam int CFG_IDX_W = 3;

  // helper h = n + (offset << 8), e1 = n x h, e2 = n x e1
  localparam int HELPER_W = NORMAL_W + 1;
  localparam int E1_W     = NORMAL_W + HELPER_W + 1;
  localparam int XPROD_W  = NORMAL_W + E1_W;
  localparam int EVEC_W   = XPROD_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NORMAL_X = 3'd0,
    CFG_NORMAL_Y = 3'd1,
    CFG_NORMAL_Z = 3'd2,
    CFG_OFFSET_X = 3'd3,
    CFG_OFFSET_Y = 3'd4,
    CFG_OFFSET_Z = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CROSS,
    ST_LOAD,
    ST_NORM,
    ST_SQ,
    ST_SQRT,
    ST_DIVLD,
    ST_DIV,
    ST_DONE
  } bld_state_t;

  typedef struct packed {
    logic ready;
    logic bad;
  } basis_status_t;

endpackage

// File: rtl/plane_orthographic_projector.sv
// Projects a stream of Q15.8 vertices onto the plane whose normal sits in
// the configuration registers, giving (u, v) in Q17.8, saturated. The first
// request after reset or after any register write stalls while the basis is
// built: the two cross products, then per basis vector a load, the
// normalizing shifts, the squares, the bit-serial square root and the
// bit-serial divider for each component. After that one vertex is taken
// every cycle while the output is not stalled, passing through the
// multiply, sum and round/saturate stages. A zero normal, or a normal
// parallel to the helper offsets, gives zero outputs with degenerate set
// until the next write.
module plane_orthographic_projector #(
  parameter int BASIS_FRAC_BITS = pop_pkg::BASIS_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // tdata: coord_x[23:0], coord_y[47:24], coord_z[71:48]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [71:0]                       in_tdata,
  // tdata: proj_u[25:0], proj_v[51:26], zero fill [55:52]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [55:0]                       out_tdata,
  // tuser: degenerate[0]
  output logic [0:0]                        out_tuser,
  input  logic                              cfg_we,
  input  logic [pop_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pop_pkg::NORMAL_W-1:0]      cfg_wdata
);
  import pop_pkg::*;

  localparam int UW = BASIS_FRAC_BITS + 3;

  // configuration registers
  logic signed [NORMAL_W-1:0] normal_r [3];
  logic        [OFFSET_W-1:0] offset_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_r[0] <= '0;
      normal_r[1] <= '0;
      normal_r[2] <= NORMAL_W'(1) << NORMAL_FRAC_BITS;
      offset_r[0] <= OFFSET_W'(2);
      offset_r[1] <= OFFSET_W'(3);
      offset_r[2] <= OFFSET_W'(4);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_NORMAL_X: normal_r[0] <= cfg_wdata;
        CFG_NORMAL_Y: normal_r[1] <= cfg_wdata;
        CFG_NORMAL_Z: normal_r[2] <= cfg_wdata;
        CFG_OFFSET_X: offset_r[0] <= cfg_wdata[OFFSET_W-1:0];
        CFG_OFFSET_Y: offset_r[1] <= cfg_wdata[OFFSET_W-1:0];
        CFG_OFFSET_Z: offset_r[2] <= cfg_wdata[OFFSET_W-1:0];
        default: ;  // unknown index ignored
      endcase
    end
  end

  // basis builder; any write (even to an unknown index) drops the cache
  logic signed [UW-1:0] basis_w [6];
  basis_status_t        status_w;

  pop_basis #(.BASIS_FRAC_BITS(BASIS_FRAC_BITS)) u_basis (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (in_tvalid),
    .abort_i  (cfg_we),
    .normal_i (normal_r),
    .offset_i (offset_r),
    .basis_o  (basis_w),
    .status_o (status_w)
  );

  // projection pipeline; requests held off until the basis is cached
  logic signed [COORD_W-1:0] coord_w [3];
  logic signed [OUT_W-1:0]   u_w, v_w;
  logic                      deg_w, pipe_ready;

  assign coord_w[0] = in_tdata[23:0];
  assign coord_w[1] = in_tdata[47:24];
  assign coord_w[2] = in_tdata[71:48];

  pop_proj #(.BASIS_FRAC_BITS(BASIS_FRAC_BITS)) u_proj (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid && status_w.ready),
    .in_ready   (pipe_ready),
    .coord_i    (coord_w),
    .basis_i    (basis_w),
    .bad_i      (status_w.bad),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .proj_u     (u_w),
    .proj_v     (v_w),
    .degenerate (deg_w)
  );

  assign in_tready = status_w.ready && pipe_ready;
  assign out_tdata = {4'b0, v_w, u_w};
  assign out_tuser = deg_w;

endmodule

// File: rtl/pop_basis.sv
module pop_basis #(
  parameter int BASIS_FRAC_BITS = pop_pkg::BASIS_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start_i,
  input  logic                                 abort_i,
  input  logic signed [pop_pkg::NORMAL_W-1:0]  normal_i [3],
  input  logic        [pop_pkg::OFFSET_W-1:0]  offset_i [3],
  output logic signed [BASIS_FRAC_BITS+2:0]    basis_o  [6],
  output pop_pkg::basis_status_t               status_o
);
  import pop_pkg::*;

  localparam int UW  = BASIS_FRAC_BITS + 3;
  localparam int QW  = BASIS_FRAC_BITS + 2;
  localparam int NW  = BASIS_FRAC_BITS + 31;
  localparam int CW  = $clog2(NW);
  localparam int SQW = 62;

  bld_state_t state_r, state_nxt;

  logic                      which_r;
  logic [2:0]                step_r;
  logic                      phase_r;
  logic [1:0]                comp_r;
  logic                      bad_r;
  logic signed [XPROD_W-1:0] prod_r;
  logic signed [EVEC_W-1:0]  e_r [2][3];
  logic        [EVEC_W-1:0]  mag_r [3];
  logic                      neg_r [3];
  logic        [59:0]        sqp_r;
  logic        [SQW-1:0]     sqv_r, sqres_r, sqbit_r;
  logic        [30:0]        s_r;
  logic        [NW-1:0]      num_r;
  logic        [30:0]        rem_r;
  logic        [QW-1:0]      q_r;
  logic        [CW-1:0]      cnt_r;
  logic signed [UW-1:0]      basis_r [6];
  logic                      ready_r, basbad_r;

  // cross product operand select: r_i = n_j*b_k - n_k*b_j
  logic [1:0] ia, ib;
  logic [1:0] cidx;
  logic       term;
  always_comb begin
    cidx = step_r[2:1];
    term = step_r[0];
    unique case (cidx)
      2'd0:    begin ia = term ? 2'd2 : 2'd1; ib = term ? 2'd1 : 2'd2; end
      2'd1:    begin ia = term ? 2'd0 : 2'd2; ib = term ? 2'd2 : 2'd0; end
      2'd2:    begin ia = term ? 2'd1 : 2'd0; ib = term ? 2'd0 : 2'd1; end
      default: begin ia = 2'd0; ib = 2'd0; end
    endcase
  end

  logic signed [HELPER_W-1:0] helper_w;
  logic signed [E1_W-1:0]     bsel_w;
  logic signed [XPROD_W-1:0]  mul_w;
  assign helper_w = $signed({normal_i[ib][NORMAL_W-1], normal_i[ib]})
                  + $signed({5'b0, offset_i[ib], 8'b0});
  assign bsel_w = which_r ? e_r[0][ib][E1_W-1:0]
                          : {{(E1_W-HELPER_W){helper_w[HELPER_W-1]}}, helper_w};
  assign mul_w  = normal_i[ia] * bsel_w;

  logic [EVEC_W-1:0] top_w, m01_w;
  assign m01_w = (mag_r[0] > mag_r[1]) ? mag_r[0] : mag_r[1];
  assign top_w = (m01_w > mag_r[2]) ? m01_w : mag_r[2];
  logic top_hi, top_lo;
  assign top_hi = |top_w[EVEC_W-1:30];
  assign top_lo = (top_w[EVEC_W-1:29] == '0);

  logic        zero_w;
  assign zero_w = (e_r[which_r][0] == '0) && (e_r[which_r][1] == '0)
               && (e_r[which_r][2] == '0);

  logic [SQW-1:0] trial_w;
  assign trial_w = sqres_r + sqbit_r;

  logic [31:0] rem2_w;
  logic        ge_w;
  logic [QW-1:0] qfin_w;
  assign rem2_w = {rem_r, num_r[NW-1]};
  assign ge_w   = rem2_w >= {1'b0, s_r};
  assign qfin_w = {q_r[QW-2:0], ge_w};

  logic cross_last, sq_last, div_last;
  assign cross_last = phase_r && (step_r == 3'd5);
  assign sq_last    = phase_r && (comp_r == 2'd2);
  assign div_last   = (cnt_r == CW'(NW - 1));

  logic [2:0] bidx;
  assign bidx = which_r ? (3'(comp_r) + 3'd3) : 3'(comp_r);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start_i && !ready_r) state_nxt = ST_CROSS;
      ST_CROSS: if (cross_last && which_r) state_nxt = ST_LOAD;
      ST_LOAD:  begin
        if (zero_w) state_nxt = which_r ? ST_DONE : ST_LOAD;
        else        state_nxt = ST_NORM;
      end
      ST_NORM:  if (!top_hi && !top_lo) state_nxt = ST_SQ;
      ST_SQ:    if (sq_last) state_nxt = ST_SQRT;
      ST_SQRT:  if (sqbit_r == '0) state_nxt = ST_DIVLD;
      ST_DIVLD: state_nxt = ST_DIV;
      ST_DIV:   begin
        if (div_last) begin
          if (comp_r == 2'd2) state_nxt = which_r ? ST_DONE : ST_LOAD;
          else                state_nxt = ST_DIVLD;
        end
      end
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
    if (abort_i) state_nxt = ST_IDLE;
  end

  // control flags and cached basis
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r  <= 1'b0;
      basbad_r <= 1'b0;
      for (int i = 0; i < 6; i++) basis_r[i] <= '0;
    end else begin
      if (state_r == ST_DIV && div_last) begin
        basis_r[bidx] <= neg_r[comp_r] ? -$signed({1'b0, qfin_w}) : $signed({1'b0, qfin_w});
      end
      if (state_r == ST_DONE) begin
        basbad_r <= bad_r;
        ready_r  <= 1'b1;
        if (bad_r) for (int i = 0; i < 6; i++) basis_r[i] <= '0;
      end
      if (abort_i) ready_r <= 1'b0;
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        which_r <= 1'b0;
        step_r  <= '0;
        phase_r <= 1'b0;
        bad_r   <= 1'b0;
      end
      ST_CROSS: begin
        phase_r <= ~phase_r;
        if (!phase_r) begin
          prod_r <= mul_w;
        end else begin
          if (!term) e_r[which_r][cidx] <= {prod_r[XPROD_W-1], prod_r};
          else       e_r[which_r][cidx] <= e_r[which_r][cidx]
                                         - {prod_r[XPROD_W-1], prod_r};
          if (step_r == 3'd5) begin
            step_r  <= '0;
            which_r <= ~which_r;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
      end
      ST_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          neg_r[i] <= e_r[which_r][i][EVEC_W-1];
          mag_r[i] <= e_r[which_r][i][EVEC_W-1] ? (~e_r[which_r][i] + 1'b1)
                                                : e_r[which_r][i];
        end
        if (zero_w) begin
          bad_r   <= 1'b1;
          which_r <= 1'b1;
        end
        comp_r  <= '0;
        phase_r <= 1'b0;
        sqv_r   <= '0;
      end
      ST_NORM: begin
        for (int i = 0; i < 3; i++) begin
          if (top_hi)      mag_r[i] <= mag_r[i] >> 1;
          else if (top_lo) mag_r[i] <= mag_r[i] << 1;
        end
      end
      ST_SQ: begin
        phase_r <= ~phase_r;
        if (!phase_r) begin
          sqp_r <= mag_r[comp_r][29:0] * mag_r[comp_r][29:0];
        end else begin
          sqv_r <= sqv_r + {2'b0, sqp_r};
          comp_r <= (comp_r == 2'd2) ? 2'd0 : comp_r + 2'd1;
        end
        sqres_r <= '0;
        sqbit_r <= SQW'(1) << 60;
      end
      ST_SQRT: begin
        if (sqbit_r == '0) begin
          s_r <= sqres_r[30:0];
        end else begin
          if (sqv_r >= trial_w) begin
            sqv_r   <= sqv_r - trial_w;
            sqres_r <= (sqres_r >> 1) + sqbit_r;
          end else begin
            sqres_r <= sqres_r >> 1;
          end
          sqbit_r <= sqbit_r >> 2;
        end
      end
      ST_DIVLD: begin
        num_r <= (NW'(mag_r[comp_r][29:0]) << BASIS_FRAC_BITS) + NW'(s_r >> 1);
        rem_r <= '0;
        q_r   <= '0;
        cnt_r <= '0;
      end
      ST_DIV: begin
        rem_r <= ge_w ? 31'(rem2_w - {1'b0, s_r}) : rem2_w[30:0];
        q_r   <= qfin_w;
        num_r <= num_r << 1;
        cnt_r <= cnt_r + 1'b1;
        if (div_last) begin
          if (comp_r == 2'd2) begin
            comp_r  <= '0;
            which_r <= 1'b1;
          end else begin
            comp_r <= comp_r + 2'd1;
          end
        end
      end
      default: ;
    endcase
  end

  assign basis_o         = basis_r;
  assign status_o.ready  = ready_r;
  assign status_o.bad    = basbad_r;

endmodule

// File: rtl/pop_proj.sv
module pop_proj #(
  parameter int BASIS_FRAC_BITS = pop_pkg::BASIS_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [pop_pkg::COORD_W-1:0]  coord_i [3],
  input  logic signed [BASIS_FRAC_BITS+2:0]   basis_i [6],
  input  logic                                bad_i,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pop_pkg::OUT_W-1:0]    proj_u,
  output logic signed [pop_pkg::OUT_W-1:0]    proj_v,
  output logic                                degenerate
);
  import pop_pkg::*;

  localparam int UW = BASIS_FRAC_BITS + 3;
  localparam int PW = COORD_W + UW;
  localparam int SW = PW + 2;
  localparam int RW = SW - BASIS_FRAC_BITS;

  logic v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3;
  assign adv3 = out_ready || !v3_r;
  assign adv2 = adv3 || !v2_r;
  assign adv1 = adv2 || !v1_r;
  assign in_ready = adv1;

  logic signed [PW-1:0] p_r [6];
  logic                 d1_r, d2_r, d3_r;
  logic signed [SW-1:0] su_r, sv_r;
  logic signed [OUT_W-1:0] u_r, w_r;

  localparam logic signed [SW-1:0] HALF = SW'(1) << (BASIS_FRAC_BITS - 1);

  function automatic logic signed [OUT_W-1:0] sat(input logic signed [SW-1:0] s);
    logic signed [RW-1:0] r;
    r = RW'(s >>> BASIS_FRAC_BITS);
    if (r[RW-1:OUT_W-1] == '0 || r[RW-1:OUT_W-1] == '1) sat = r[OUT_W-1:0];
    else if (r[RW-1]) sat = {1'b1, {(OUT_W-1){1'b0}}};
    else              sat = {1'b0, {(OUT_W-1){1'b1}}};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      for (int i = 0; i < 3; i++) begin
        p_r[i]     <= coord_i[i] * basis_i[i];
        p_r[i + 3] <= coord_i[i] * basis_i[i + 3];
      end
      d1_r <= bad_i;
    end
    if (adv2) begin
      su_r <= SW'(p_r[0]) + SW'(p_r[1]) + SW'(p_r[2]) + HALF;
      sv_r <= SW'(p_r[3]) + SW'(p_r[4]) + SW'(p_r[5]) + HALF;
      d2_r <= d1_r;
    end
    if (adv3) begin
      u_r  <= sat(su_r);
      w_r  <= sat(sv_r);
      d3_r <= d2_r;
    end
  end

  assign out_valid  = v3_r;
  assign proj_u     = u_r;
  assign proj_v     = w_r;
  assign degenerate = d3_r;

endmodule
